FILE: sv/btpf_pkg.sv
// Shared types, codes and defaults for the binary trie prefix filter.
package btpf_pkg;

  localparam int NodeCountDef = 1024;
  localparam int WayBitsDef   = 8;
  localparam int KeyBitsDef   = 32;

  localparam int ModeW   = 2;
  localparam int KeyW    = 32;
  localparam int PlenW   = 6;
  localparam int MaskW   = 8;
  localparam int StatusW = 2;
  localparam int CountW  = 11;

  localparam logic [PlenW-1:0] KeyWidthReset = 6'd32;

  localparam logic [ModeW-1:0] MODE_INSERT = 2'd0;
  localparam logic [ModeW-1:0] MODE_REMOVE = 2'd1;
  localparam logic [ModeW-1:0] MODE_QUERY  = 2'd2;

  localparam logic [StatusW-1:0] ST_OK        = 2'd0;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [StatusW-1:0] ST_FULL      = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_EVAL  = 4'b0010,
    S_ALLOC = 4'b0100,
    S_DONE  = 4'b1000
  } walk_state_e;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               is_blocked;
    logic [CountW-1:0]  entry_count;
  } rsp_word_t;

endpackage

FILE: sv/btpf_if.sv
// Request and response channel interfaces.
interface btpf_req_if import btpf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ModeW-1:0] mode;
  logic [KeyW-1:0]  key;
  logic [PlenW-1:0] prefix_len;
  logic [MaskW-1:0] way_mask;
  modport source (output valid, mode, key, prefix_len, way_mask, input ready);
  modport sink   (input valid, mode, key, prefix_len, way_mask, output ready);
endinterface

interface btpf_rsp_if import btpf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic               is_blocked;
  logic [CountW-1:0]  entry_count;
  modport source (output valid, status, is_blocked, entry_count, input ready);
  modport sink   (input valid, status, is_blocked, entry_count, output ready);
endinterface

FILE: sv/binary_trie_prefix_filter.sv
// Top level of the binary trie prefix filter.
//
//  port group  dir   handshake       carries
//  req         in    valid/ready     mode, key, prefix_len, way_mask
//  rsp         out   valid/ready     status, is_blocked, entry_count
//  apb         in    sel/penable     key_width register at byte 0
//
// One request at a time: accept, then one eval step per trie level visited (the
// node memory read port), an extra alloc step for each node allocated, and a
// final done step. Reset returns the sequencer to idle, sets the allocation
// pointer to one and clears the count; node memory needs no clearing pass.
// A stalled result holds in the output register.
module binary_trie_prefix_filter import btpf_pkg::*; #(
  parameter int NODE_COUNT = NodeCountDef,
  parameter int WAY_BITS   = WayBitsDef,
  parameter int KEY_BITS   = KeyBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  btpf_req_if.sink    req,
  btpf_rsp_if.source  rsp,
  input  logic        apb_sel_i,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IdxW = $clog2(NODE_COUNT);
  localparam int EntW = 2 * IdxW + 1 + WAY_BITS;

  logic [PlenW-1:0] key_width_q;
  logic             rd_en, wr_en;
  logic [IdxW-1:0]  rd_addr, wr_addr;
  logic [EntW-1:0]  rd_data, wr_data;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? '0 : {{(32-PlenW){1'b0}}, key_width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_width_q <= KeyWidthReset;
    end else if (apb_sel_i && penable && pwrite && !paddr[2]) begin
      key_width_q <= pwdata[PlenW-1:0];
    end
  end

  btpf_node_ram #(.NODE_COUNT(NODE_COUNT), .WAY_BITS(WAY_BITS)) u_ram (
    .clk_i, .rst_ni,
    .rd_en_i(rd_en), .rd_addr_i(rd_addr), .rd_data_o(rd_data),
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data)
  );

  btpf_walk #(.NODE_COUNT(NODE_COUNT), .WAY_BITS(WAY_BITS), .KEY_BITS(KEY_BITS)) u_walk (
    .clk_i, .rst_ni,
    .key_width_i(key_width_q),
    .req, .rsp,
    .rd_en_o(rd_en), .rd_addr_o(rd_addr), .rd_data_i(rd_data),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data)
  );

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while busy");

  a_hit_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.status != ST_OK |-> !rsp.is_blocked)
    else $error("hit reported with error status");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> 32'(rsp.entry_count) <= 32'(NODE_COUNT))
    else $error("blocked count above node count");

endmodule

FILE: sv/btpf_node_ram.sv
// Trie node memory: one write port, one registered read port.
module btpf_node_ram import btpf_pkg::*; #(
  parameter int NODE_COUNT = NodeCountDef,
  parameter int WAY_BITS   = WayBitsDef,
  localparam int IdxW = $clog2(NODE_COUNT),
  localparam int EntW = 2 * IdxW + 1 + WAY_BITS
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output logic [EntW-1:0] rd_data_o,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  logic [EntW-1:0] wr_data_i
);

  logic [EntW-1:0] mem [NODE_COUNT];
  logic [EntW-1:0] rd_q;
  logic            root_ok_q;
  logic            rd_root_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  // root is the only entry read before it is written
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_ok_q <= 1'b0;
      rd_root_q <= 1'b0;
    end else begin
      if (wr_en_i && wr_addr_i == '0) begin
        root_ok_q <= 1'b1;
      end
      if (rd_en_i) begin
        rd_root_q <= (rd_addr_i == '0) && !(root_ok_q || (wr_en_i && wr_addr_i == '0));
      end
    end
  end

  assign rd_data_o = rd_root_q ? '0 : rd_q;

endmodule

FILE: sv/btpf_walk.sv
// Request sequencer: walks the trie one node per cycle while no node is being allocated, and updates it.
module btpf_walk import btpf_pkg::*; #(
  parameter int NODE_COUNT = NodeCountDef,
  parameter int WAY_BITS   = WayBitsDef,
  parameter int KEY_BITS   = KeyBitsDef,
  localparam int IdxW = $clog2(NODE_COUNT),
  localparam int EntW = 2 * IdxW + 1 + WAY_BITS,
  localparam int NfW  = $clog2(NODE_COUNT + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [PlenW-1:0] key_width_i,
  btpf_req_if.sink         req,
  btpf_rsp_if.source       rsp,
  output logic             rd_en_o,
  output logic [IdxW-1:0]  rd_addr_o,
  input  logic [EntW-1:0]  rd_data_i,
  output logic             wr_en_o,
  output logic [IdxW-1:0]  wr_addr_o,
  output logic [EntW-1:0]  wr_data_o
);

  localparam logic [PlenW-1:0] KeyBitsW = PlenW'(KEY_BITS);

  walk_state_e         state_q, state_d;
  logic [ModeW-1:0]    mode_q;
  logic [WAY_BITS-1:0] mask_q;
  logic [KeyW-1:0]     key_q, key_d;
  logic [PlenW-1:0]    plen_q, width_q, lvl_q, lvl_d;
  logic [IdxW-1:0]     cur_q, cur_d, new_q;
  logic                zero_q, zero_d;
  logic [NfW-1:0]      free_q, free_d;
  logic [NfW-1:0]      cnt_q, cnt_d;
  logic [StatusW-1:0]  st_q, st_d;
  logic                hit_q, hit_d;
  rsp_word_t           out_q;
  logic                out_vld_q;

  logic [PlenW-1:0]    width;
  logic [PlenW-1:0]    plen_in;
  logic [EntW-1:0]     nd;
  logic [IdxW-1:0]     nd_c0, nd_c1, child;
  logic                nd_blk;
  logic [WAY_BITS-1:0] nd_ways, rm_ways;
  logic                bit_now, at_end, load_out;
  logic [NfW+CountW-1:0] cnt_ext;

  assign width   = (key_width_i > KeyBitsW) ? KeyBitsW : key_width_i;
  assign plen_in = (req.prefix_len > width) ? width : req.prefix_len;

  assign nd      = zero_q ? '0 : rd_data_i;
  assign nd_c0   = nd[EntW-1 -: IdxW];
  assign nd_c1   = nd[EntW-IdxW-1 -: IdxW];
  assign nd_blk  = nd[WAY_BITS];
  assign nd_ways = nd[WAY_BITS-1:0];
  assign bit_now = key_q[KeyW-1];
  assign child   = bit_now ? nd_c1 : nd_c0;
  assign rm_ways = nd_ways & ~mask_q;
  assign at_end  = (mode_q == MODE_QUERY) ? (lvl_q == width_q) : (lvl_q == plen_q);

  assign req.ready = (state_q == S_IDLE);
  assign load_out  = (state_q == S_DONE) && (!out_vld_q || rsp.ready);

  always_comb begin
    state_d   = state_q;
    key_d     = key_q;
    lvl_d     = lvl_q;
    cur_d     = cur_q;
    zero_d    = 1'b0;
    free_d    = free_q;
    cnt_d     = cnt_q;
    st_d      = st_q;
    hit_d     = hit_q;
    rd_en_o   = 1'b0;
    rd_addr_o = '0;
    wr_en_o   = 1'b0;
    wr_addr_o = cur_q;
    wr_data_o = nd;
    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          // align the top significant key bit to the MSB
          key_d     = req.key << (PlenW'(KeyW) - width);
          lvl_d     = '0;
          cur_d     = '0;
          st_d      = ST_OK;
          hit_d     = 1'b0;
          rd_en_o   = 1'b1;
          rd_addr_o = '0;
          state_d   = (req.mode == MODE_INSERT || req.mode == MODE_REMOVE ||
                       req.mode == MODE_QUERY) ? S_EVAL : S_DONE;
        end
      end
      S_EVAL: begin
        if (mode_q == MODE_QUERY && nd_blk && |(nd_ways & mask_q)) begin
          hit_d   = 1'b1;
          state_d = S_DONE;
        end else if (at_end) begin
          state_d = S_DONE;
          if (mode_q == MODE_INSERT) begin
            wr_en_o   = 1'b1;
            wr_data_o = {nd_c0, nd_c1, 1'b1, nd_ways | mask_q};
            if (!nd_blk) begin
              cnt_d = cnt_q + 1'b1;
            end
          end else if (mode_q == MODE_REMOVE) begin
            wr_en_o   = 1'b1;
            wr_data_o = {nd_c0, nd_c1, nd_blk && (rm_ways != '0), rm_ways};
            if (nd_blk && rm_ways == '0 && cnt_q != '0) begin
              cnt_d = cnt_q - 1'b1;
            end
          end
        end else if (child != '0) begin
          // descend and read the child at once
          cur_d     = child;
          lvl_d     = lvl_q + 1'b1;
          key_d     = key_q << 1;
          rd_en_o   = 1'b1;
          rd_addr_o = child;
        end else if (mode_q == MODE_INSERT) begin
          if (free_q >= NfW'(NODE_COUNT)) begin
            st_d    = ST_FULL;
            state_d = S_DONE;
          end else begin
            // link the new node into its parent, clear it next cycle
            wr_en_o   = 1'b1;
            wr_data_o = bit_now ? {nd_c0, free_q[IdxW-1:0], nd_blk, nd_ways}
                                : {free_q[IdxW-1:0], nd_c1, nd_blk, nd_ways};
            free_d    = free_q + 1'b1;
            state_d   = S_ALLOC;
          end
        end else begin
          if (mode_q == MODE_REMOVE) begin
            st_d = ST_NOT_FOUND;
          end
          state_d = S_DONE;
        end
      end
      S_ALLOC: begin
        wr_en_o   = 1'b1;
        wr_addr_o = new_q;
        wr_data_o = '0;
        cur_d     = new_q;
        lvl_d     = lvl_q + 1'b1;
        key_d     = key_q << 1;
        zero_d    = 1'b1;
        state_d   = S_EVAL;
      end
      S_DONE: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign cnt_ext = {{CountW{1'b0}}, cnt_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      free_q    <= NfW'(1);
      cnt_q     <= '0;
      zero_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      free_q  <= free_d;
      cnt_q   <= cnt_d;
      zero_q  <= zero_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (rsp.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    lvl_q <= lvl_d;
    cur_q <= cur_d;
    st_q  <= st_d;
    hit_q <= hit_d;
    if (state_q == S_IDLE && req.valid) begin
      mode_q  <= req.mode;
      mask_q  <= req.way_mask[WAY_BITS-1:0];
      plen_q  <= plen_in;
      width_q <= width;
    end
    if (state_q == S_EVAL) begin
      new_q <= free_q[IdxW-1:0];
    end
    if (load_out) begin
      out_q <= '{status: st_q, is_blocked: hit_q, entry_count: cnt_ext[CountW-1:0]};
    end
  end

  assign rsp.valid       = out_vld_q;
  assign rsp.status      = out_q.status;
  assign rsp.is_blocked  = out_q.is_blocked;
  assign rsp.entry_count = out_q.entry_count;

endmodule

FILE: tb/binary_trie_prefix_filter_tb.sv
// Self-checking testbench for the binary trie prefix filter: random and directed requests.
module binary_trie_prefix_filter_tb;
  import btpf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Nodes = NodeCountDef;
  localparam logic [2:0] ADDR_KEY_WIDTH = 3'd0;

  typedef struct packed {
    logic [ModeW-1:0] mode;
    logic [KeyW-1:0]  key;
    logic [PlenW-1:0] plen;
    logic [MaskW-1:0] ways;
  } trie_req_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic apb_sel_i = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  btpf_req_if req ();
  btpf_rsp_if rsp ();

  binary_trie_prefix_filter uut (
    .clk_i, .rst_ni, .req(req.sink), .rsp(rsp.source),
    .apb_sel_i, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow trie
  logic [9:0]        kid0 [Nodes];
  logic [9:0]        kid1 [Nodes];
  logic              blk  [Nodes];
  logic [MaskW-1:0]  wmask[Nodes];
  int unsigned       next_node;
  int unsigned       blk_count;
  logic [PlenW-1:0]  key_width;

  trie_req_t pend_q[$];
  rsp_word_t lookup_q[$];
  logic [31:0] key_pool[8];
  int errors = 0;
  bit quiet = 0;
  bit req_acc = 0;
  int req_gap = 0, rsp_gap = 0;

  task automatic report(string what, int got, int want);
    errors++;
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
  endtask

  function automatic logic [9:0] child(int n, logic b);
    return b ? kid1[n] : kid0[n];
  endfunction

  function automatic rsp_word_t filter_answer(trie_req_t r);
    rsp_word_t a;
    int w, pl, node, c;
    logic b;
    bit stop;
    a = '0;
    stop = 0;
    w = (key_width > KeyBitsDef) ? KeyBitsDef : int'(key_width);
    pl = (int'(r.plen) > w) ? w : int'(r.plen);
    node = 0;
    case (r.mode)
      MODE_INSERT: begin
        for (int i = 0; i < pl && !stop; i++) begin
          b = r.key[w-1-i];
          c = int'(child(node, b));
          if (c == 0) begin
            if (next_node >= Nodes) begin
              a.status = ST_FULL;
              stop = 1;
            end else begin
              c = next_node++;
              kid0[c] = '0; kid1[c] = '0; blk[c] = 0; wmask[c] = '0;
              if (b) kid1[node] = c[9:0];
              else kid0[node] = c[9:0];
            end
          end
          if (!stop) node = c;
        end
        if (!stop) begin
          if (!blk[node]) begin
            blk[node] = 1;
            blk_count++;
          end
          wmask[node] |= r.ways;
        end
      end
      MODE_REMOVE: begin
        for (int i = 0; i < pl && !stop; i++) begin
          node = int'(child(node, r.key[w-1-i]));
          if (node == 0) begin
            a.status = ST_NOT_FOUND;
            stop = 1;
          end
        end
        if (!stop) begin
          wmask[node] &= ~r.ways;
          if (wmask[node] == '0 && blk[node]) begin
            blk[node] = 0;
            if (blk_count > 0) blk_count--;
          end
        end
      end
      MODE_QUERY: begin
        if (blk[0] && (wmask[0] & r.ways) != '0) a.is_blocked = 1'b1;
        for (int i = 0; i < w && !a.is_blocked && !stop; i++) begin
          node = int'(child(node, r.key[w-1-i]));
          if (node == 0) stop = 1;
          else if (blk[node] && (wmask[node] & r.ways) != '0) a.is_blocked = 1'b1;
        end
      end
      default: ;
    endcase
    a.entry_count = blk_count[CountW-1:0];
    return a;
  endfunction

  // driver: request side
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      req.valid <= 1'b0;
    end else if (req.valid && !req_acc) begin
      // hold until taken
    end else if (req_gap > 0) begin
      req_gap--;
      req.valid <= 1'b0;
    end else if (pend_q.size() > 0 && !quiet && $urandom_range(0, 7) == 0) begin
      req_gap = $urandom_range(0, 12);
      req.valid <= 1'b0;
    end else if (pend_q.size() > 0) begin
      trie_req_t t;
      t = pend_q.pop_front();
      req.valid <= 1'b1;
      req.mode <= t.mode;
      req.key <= t.key;
      req.prefix_len <= t.plen;
      req.way_mask <= t.ways;
    end else begin
      req.valid <= 1'b0;
    end
  end

  // driver: response side stalls
  always @(negedge clk_i) begin
    if (!rst_ni || quiet) begin
      rsp.ready <= 1'b1;
    end else if (rsp_gap > 0) begin
      rsp_gap--;
      rsp.ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      rsp_gap = $urandom_range(0, 12);
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    req_acc = 0;
    if (rst_ni) begin
      if (rsp.valid && rsp.ready) begin
        if (lookup_q.size() == 0) begin
          report("unexpected word", int'(rsp.entry_count), 0);
        end else begin
          rsp_word_t e;
          e = lookup_q.pop_front();
          if (rsp.status !== e.status)
            report("status", int'(rsp.status), int'(e.status));
          if (rsp.is_blocked !== e.is_blocked)
            report("is_blocked", int'(rsp.is_blocked), int'(e.is_blocked));
          if (rsp.entry_count !== e.entry_count)
            report("entry_count", int'(rsp.entry_count), int'(e.entry_count));
        end
      end
      if (req.valid && req.ready) begin
        trie_req_t t;
        req_acc = 1;
        t = {req.mode, req.key, req.prefix_len, req.way_mask};
        lookup_q.push_back(filter_answer(t));
      end
    end
  end

  task automatic add(logic [ModeW-1:0] m, logic [31:0] k, int pl, logic [7:0] w);
    trie_req_t t;
    t.mode = m; t.key = k; t.plen = pl[PlenW-1:0]; t.ways = w;
    pend_q.push_back(t);
  endtask

  task automatic add_random(int n, int long_pct);
    logic [31:0] k;
    int r, pl;
    logic [ModeW-1:0] m;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 35) m = MODE_INSERT;
      else if (r < 50) m = MODE_REMOVE;
      else if (r < 97) m = MODE_QUERY;
      else m = 2'd3;
      if ($urandom_range(0, 9) < 7)
        k = key_pool[$urandom_range(0, 7)] ^ ($urandom >> $urandom_range(1, 31));
      else
        k = $urandom;
      pl = ($urandom_range(0, 99) < long_pct) ? $urandom_range(0, 63) : $urandom_range(0, 10);
      add(m, k, pl, ($urandom_range(0, 3) == 0) ? (8'd1 << $urandom_range(0, 7)) : 8'($urandom));
    end
  endtask

  // drain everything, then let the block settle before a register write
  task automatic drain();
    while (pend_q.size() > 0 || req.valid || lookup_q.size() > 0) @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic set_key_width(logic [5:0] v);
    @(negedge clk_i);
    apb_sel_i <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_KEY_WIDTH; pwdata <= {26'd0, v};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    key_width = v;
    @(negedge clk_i);
    apb_sel_i <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  initial begin
    req.valid = 1'b0; req.mode = '0; req.key = '0; req.prefix_len = '0; req.way_mask = '0;
    rsp.ready = 1'b0;
    key_width = KeyWidthReset;
    next_node = 1;
    blk_count = 0;
    for (int i = 0; i < Nodes; i++) begin
      kid0[i] = '0; kid1[i] = '0; blk[i] = 0; wmask[i] = '0;
    end
    foreach (key_pool[i]) key_pool[i] = $urandom;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    add(MODE_QUERY, 32'hFFFF_FFFF, 0, 8'hFF);
    add(MODE_INSERT, 32'h0, 0, 8'h00);          // root blocked, no ways
    add(MODE_QUERY, 32'h1234_5678, 0, 8'hFF);
    add(MODE_INSERT, 32'hFFFF_FFFF, 63, 8'hFF);  // clamped to full width
    add(MODE_QUERY, 32'hFFFF_FFFF, 5, 8'h80);
    add(MODE_QUERY, 32'hFFFF_FFFE, 0, 8'hFF);
    add(MODE_REMOVE, 32'h0, 32, 8'hFF);          // path absent
    add(MODE_REMOVE, 32'hFFFF_0000, 16, 8'h01);  // existing unblocked node
    add(MODE_INSERT, 32'h8000_0000, 1, 8'h0F);
    add(MODE_REMOVE, 32'h8000_0000, 1, 8'h03);   // ways left, stays blocked
    add(MODE_QUERY, 32'hC000_0000, 0, 8'h04);
    add(MODE_REMOVE, 32'h8000_0000, 1, 8'hFF);
    add(MODE_QUERY, 32'hC000_0000, 0, 8'h04);
    add(2'd3, 32'hFFFF_FFFF, 63, 8'hFF);
    add(MODE_REMOVE, 32'h0, 0, 8'hFF);           // unblock root
    add(MODE_INSERT, 32'h0000_0000, 32, 8'hAA);
    add(MODE_QUERY, 32'h0000_0000, 32, 8'h55);
    add(MODE_QUERY, 32'h0000_0000, 32, 8'h02);
    add_random(280, 15);
    drain();

    set_key_width(6'd63);   // wider than the key
    add_random(140, 15);
    drain();

    set_key_width(6'd0);    // everything acts on the root
    add(MODE_INSERT, 32'hDEAD_BEEF, 20, 8'h10);
    add(MODE_QUERY, 32'h0, 0, 8'h10);
    add(MODE_REMOVE, 32'h1, 3, 8'h10);
    add_random(40, 30);
    drain();

    set_key_width(6'd1);
    add_random(60, 30);
    drain();

    set_key_width(6'd5);
    add_random(90, 30);
    drain();

    set_key_width(6'd32);
    for (int i = 0; i < 45; i++) add(MODE_INSERT, $urandom, 32, 8'($urandom));  // fill the store
    add(MODE_INSERT, 32'h5555_5555, 32, 8'hFF);
    drain();
    quiet = 1;
    add_random(110, 40);
    drain();

    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: binary_trie_prefix_filter.f
sv/btpf_pkg.sv
sv/btpf_if.sv
sv/btpf_node_ram.sv
sv/btpf_walk.sv
sv/binary_trie_prefix_filter.sv
tb/binary_trie_prefix_filter_tb.sv
